FILE: sv/dplm_pkg.sv
// Shared types and constants for the demand paging LRU frame manager.
package dplm_pkg;

    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_ACCESS   = 1'b1;

    localparam logic [7:0] FiuReset        = 8'd128;
    localparam int         PagesPerProcess = 64;

    typedef enum logic [2:0] {
        STAT_HIT           = 3'd0,
        STAT_PAGE_IN       = 3'd1,
        STAT_FAULT         = 3'd2,
        STAT_UNKNOWN       = 3'd3,
        STAT_LOADED        = 3'd4,
        STAT_TABLE_FULL    = 3'd5,
        STAT_LOAD_NO_FRAME = 3'd6
    } status_t;

    typedef struct packed {
        logic        func;
        logic [15:0] pid;
        logic [5:0]  virtual_page;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [6:0]  frame;
        logic        evicted;
        logic [15:0] evicted_pid;
        logic [5:0]  evicted_page;
    } rsp_t;

    // search packet passed down the cell row
    typedef struct packed {
        logic        valid;
        logic        free_found;
        logic        vic_found;
        logic [31:0] vic_stamp;
        logic [15:0] vic_pid;
        logic [5:0]  vic_page;
        logic        hit_found;
    } scan_t;

    // broadcast update to the cell row
    typedef struct packed {
        logic        en;
        logic        touch;
        logic        clear;
        logic        pinned;
        logic        has_page;
        logic [15:0] pid;
        logic [5:0]  page;
        logic [31:0] stamp;
    } cell_wr_t;

endpackage

FILE: sv/dplm_cell.sv
// One physical frame cell: holds the frame's state and updates the search packet.
module dplm_cell #(
    parameter int IDX = 0,
    parameter int FW  = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         fiu,
    input  logic [15:0]        q_pid,
    input  logic [5:0]         q_vp,
    input  dplm_pkg::cell_wr_t wr,
    input  logic [FW-1:0]      wr_idx,
    input  dplm_pkg::scan_t    scan_in,
    input  logic [FW-1:0]      free_idx_in,
    input  logic [FW-1:0]      vic_idx_in,
    input  logic [FW-1:0]      hit_idx_in,
    output dplm_pkg::scan_t    scan_out,
    output logic [FW-1:0]      free_idx_out,
    output logic [FW-1:0]      vic_idx_out,
    output logic [FW-1:0]      hit_idx_out
);
    import dplm_pkg::*;

    localparam logic [FW-1:0] MyIdx = FW'(IDX);

    logic        valid_reg, valid_next;
    logic        pinned_reg, pinned_next;
    logic        has_page_reg, has_page_next;
    logic [15:0] pid_reg, pid_next;
    logic [5:0]  page_reg, page_next;
    logic [31:0] stamp_reg, stamp_next;
    scan_t       scan_reg, scan_next;
    logic [FW-1:0] fidx_reg, fidx_next, vidx_reg, vidx_next, hidx_reg, hidx_next;
    logic        active;
    logic        sel;

    assign active = (32'(IDX) < 32'(fiu));
    assign sel    = wr.en && (wr_idx == MyIdx);

    always_comb
    begin
        valid_next    = valid_reg;
        pinned_next   = pinned_reg;
        has_page_next = has_page_reg;
        pid_next      = pid_reg;
        page_next     = page_reg;
        stamp_next    = stamp_reg;
        if (wr.clear)
        begin
            valid_next  = 1'b0;
            pinned_next = 1'b0;
        end
        else if (sel)
        begin
            stamp_next = wr.stamp;
            if (!wr.touch)
            begin
                valid_next    = 1'b1;
                pinned_next   = wr.pinned;
                has_page_next = wr.has_page;
                pid_next      = wr.pid;
                page_next     = wr.page;
            end
        end
    end

    always_comb
    begin
        scan_next = scan_in;
        fidx_next = free_idx_in;
        vidx_next = vic_idx_in;
        hidx_next = hit_idx_in;
        if (!scan_in.free_found && active && !valid_reg)
        begin
            scan_next.free_found = 1'b1;
            fidx_next            = MyIdx;
        end
        // strict less-than keeps the lowest index on equal stamps
        if (active && valid_reg && !pinned_reg &&
            (!scan_in.vic_found || (stamp_reg < scan_in.vic_stamp)))
        begin
            scan_next.vic_found = 1'b1;
            scan_next.vic_stamp = stamp_reg;
            scan_next.vic_pid   = pid_reg;
            scan_next.vic_page  = page_reg;
            vidx_next           = MyIdx;
        end
        if (!scan_in.hit_found && valid_reg && has_page_reg &&
            (pid_reg == q_pid) && (page_reg == q_vp))
        begin
            scan_next.hit_found = 1'b1;
            hidx_next           = MyIdx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            pinned_reg <= 1'b0;
            scan_reg   <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            pinned_reg <= pinned_next;
            scan_reg   <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        has_page_reg <= has_page_next;
        pid_reg      <= pid_next;
        page_reg     <= page_next;
        stamp_reg    <= stamp_next;
        fidx_reg     <= fidx_next;
        vidx_reg     <= vidx_next;
        hidx_reg     <= hidx_next;
    end

    assign scan_out     = scan_reg;
    assign free_idx_out = fidx_reg;
    assign vic_idx_out  = vidx_reg;
    assign hit_idx_out  = hidx_reg;

endmodule

FILE: sv/demand_paging_lru_frame_manager_top.sv
// Top level of the demand paging frame manager with global LRU replacement.
//
//  channel  | handshake                 | beat
//  ---------+---------------------------+---------------------------------------
//  req      | req_valid / req_ready     | func, pid, virtual_page
//  rsp      | rsp_valid / rsp_ready     | status, frame, evicted, evicted_pid/page
//  cfg      | cfg_we (no back-pressure) | frames_in_use
//
//  One request at a time; the search packet walks the frame cell row, one
//  cell per cycle. Reset clears all frames, the process table and the use
//  clock at once; no clearing pass. A stalled rsp holds the decision
//  stage; a new req is still taken while the last result waits.
module demand_paging_lru_frame_manager_top #(
    parameter int NUM_FRAMES    = 128,
    parameter int NUM_PROCESSES = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_data,
    input  logic           req_valid,
    output logic           req_ready,
    input  dplm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dplm_pkg::rsp_t rsp
);
    import dplm_pkg::*;

    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int PCW = $clog2(NUM_PROCESSES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic          start_reg, start_next;
    req_t          q_reg, q_next;
    logic [7:0]    fiu_reg, fiu_next;
    logic [31:0]   clock_reg, clock_next;
    logic [15:0]   ids_reg [NUM_PROCESSES];
    logic [15:0]   ids_next [NUM_PROCESSES];
    logic [PCW-1:0] count_reg, count_next;
    scan_t         res_reg, res_next;
    logic [FW-1:0] rfidx_reg, rfidx_next, rvidx_reg, rvidx_next, rhidx_reg, rhidx_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    scan_t         chain [NUM_FRAMES+1];
    logic [FW-1:0] fidx [NUM_FRAMES+1];
    logic [FW-1:0] vidx [NUM_FRAMES+1];
    logic [FW-1:0] hidx [NUM_FRAMES+1];

    cell_wr_t      wr;
    logic [FW-1:0] wr_idx;

    logic          accept;
    logic          fire;
    logic          known;
    logic          take_ok;
    logic          evict;
    logic [FW-1:0] take_idx;
    logic [31:0]   clock_inc;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign fire      = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);

    // packet entering the row
    assign chain[0] = '{valid: start_reg, default: '0};
    assign fidx[0]  = '0;
    assign vidx[0]  = '0;
    assign hidx[0]  = '0;

    for (genvar g = 0; g < NUM_FRAMES; g++)
    begin : g_cell
        dplm_cell #(
            .IDX (g),
            .FW  (FW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .fiu          (fiu_reg),
            .q_pid        (q_reg.pid),
            .q_vp         (q_reg.virtual_page),
            .wr           (wr),
            .wr_idx       (wr_idx),
            .scan_in      (chain[g]),
            .free_idx_in  (fidx[g]),
            .vic_idx_in   (vidx[g]),
            .hit_idx_in   (hidx[g]),
            .scan_out     (chain[g+1]),
            .free_idx_out (fidx[g+1]),
            .vic_idx_out  (vidx[g+1]),
            .hit_idx_out  (hidx[g+1])
        );
    end

    // any matching live table entry marks the pid known, so a plain match is enough
    always_comb
    begin
        known = 1'b0;
        for (int i = 0; i < NUM_PROCESSES; i++)
        begin
            if ((PCW'(i) < count_reg) && (ids_reg[i] == q_reg.pid))
            begin
                known = 1'b1;
            end
        end
    end

    assign clock_inc = clock_reg + 32'd1;
    assign take_ok   = res_reg.free_found || res_reg.vic_found;
    assign evict     = !res_reg.free_found && res_reg.vic_found;
    assign take_idx  = res_reg.free_found ? rfidx_reg : rvidx_reg;

    always_comb
    begin
        state_next     = state_reg;
        start_next     = accept;
        q_next         = q_reg;
        fiu_next       = fiu_reg;
        clock_next     = clock_reg;
        ids_next       = ids_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        rfidx_next     = rfidx_reg;
        rvidx_next     = rvidx_reg;
        rhidx_next     = rhidx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        wr             = '0;
        wr.clear       = cfg_we;
        wr.pid         = q_reg.pid;
        wr.page        = q_reg.virtual_page;
        wr.stamp       = clock_inc;
        wr_idx         = take_idx;

        if (cfg_we)
        begin
            fiu_next   = cfg_data;
            count_next = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    q_next     = req;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain[NUM_FRAMES].valid)
                begin
                    res_next   = chain[NUM_FRAMES];
                    rfidx_next = fidx[NUM_FRAMES];
                    rvidx_next = vidx[NUM_FRAMES];
                    rhidx_next = hidx[NUM_FRAMES];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (fire)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    rsp_next.status = STAT_HIT;
                    if (q_reg.func == FUNC_REGISTER)
                    begin
                        if (count_reg >= PCW'(NUM_PROCESSES))
                        begin
                            rsp_next.status = STAT_TABLE_FULL;
                        end
                        else if (!take_ok)
                        begin
                            rsp_next.status = STAT_LOAD_NO_FRAME;
                        end
                        else
                        begin
                            rsp_next.status = STAT_LOADED;
                            rsp_next.frame  = 7'(take_idx);
                            rsp_next.evicted      = evict;
                            rsp_next.evicted_pid  = evict ? res_reg.vic_pid : 16'd0;
                            rsp_next.evicted_page = evict ? res_reg.vic_page : 6'd0;
                            wr.en       = 1'b1;
                            wr.pinned   = 1'b1;
                            wr.has_page = 1'b0;
                            clock_next  = clock_inc;
                            for (int i = 0; i < NUM_PROCESSES; i++)
                            begin
                                if (PCW'(i) == count_reg)
                                begin
                                    ids_next[i] = q_reg.pid;
                                end
                            end
                            count_next = count_reg + PCW'(1);
                        end
                    end
                    else
                    begin
                        clock_next = clock_inc;
                        if (!known)
                        begin
                            rsp_next.status = STAT_UNKNOWN;
                        end
                        else if ({1'b0, q_reg.virtual_page} >= 7'(PagesPerProcess))
                        begin
                            rsp_next.status = STAT_FAULT;
                        end
                        else if (res_reg.hit_found)
                        begin
                            rsp_next.status = STAT_HIT;
                            rsp_next.frame  = 7'(rhidx_reg);
                            wr.en    = 1'b1;
                            wr.touch = 1'b1;
                            wr_idx   = rhidx_reg;
                        end
                        else if (!take_ok)
                        begin
                            rsp_next.status = STAT_FAULT;
                        end
                        else
                        begin
                            rsp_next.status = STAT_PAGE_IN;
                            rsp_next.frame  = 7'(take_idx);
                            rsp_next.evicted      = evict;
                            rsp_next.evicted_pid  = evict ? res_reg.vic_pid : 16'd0;
                            rsp_next.evicted_page = evict ? res_reg.vic_page : 6'd0;
                            wr.en       = 1'b1;
                            wr.pinned   = 1'b0;
                            wr.has_page = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            fiu_reg       <= FiuReset;
            clock_reg     <= 32'd0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            fiu_reg       <= fiu_next;
            clock_reg     <= clock_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        ids_reg   <= ids_next;
        res_reg   <= res_next;
        rfidx_reg <= rfidx_next;
        rvidx_reg <= rvidx_next;
        rhidx_reg <= rhidx_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/dplm_chk.sv
// Port-level checker for the frame manager, bound to the top level.
module dplm_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           cfg_we,
    input logic [7:0]     cfg_data,
    input logic           req_valid,
    input logic           req_ready,
    input dplm_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input dplm_pkg::rsp_t rsp
);
    import dplm_pkg::*;

    // a held result beat does not change
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp beat changed while stalled");

    // one request in flight: busy right after a request beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // failures carry no frame
    a_fail_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_FAULT || rsp.status == STAT_UNKNOWN ||
                      rsp.status == STAT_TABLE_FULL ||
                      rsp.status == STAT_LOAD_NO_FRAME) |-> rsp.frame == 7'd0)
        else $error("frame reported on failure");

    // eviction only when a frame was filled
    a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.evicted |->
            (rsp.status == STAT_PAGE_IN || rsp.status == STAT_LOADED))
        else $error("eviction on wrong status");

endmodule

bind demand_paging_lru_frame_manager_top dplm_chk u_dplm_chk (.*);

FILE: sim/tb_demand_paging_lru_frame_manager_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the demand paging LRU frame manager top level.

import dplm_pkg::*;

// Frame manager predictor and store of expected responses
class frame_scoreboard;
    localparam int NF = 128;
    localparam int NP = 10;
    localparam int PPP = 64;

    bit [7:0]  fiu;
    bit        f_used  [NF];
    bit [15:0] f_pid   [NF];
    bit [6:0]  f_page  [NF];     // bit 6 set: no page held
    bit        f_pin   [NF];
    bit [31:0] f_stamp [NF];
    bit [15:0] proc_id [NP];
    int        proc_cnt;
    bit [7:0]  page_map [NP*PPP]; // bit 7 set: unmapped
    bit [31:0] use_clk;
    rsp_t      pending [$];
    int        errors;
    int        checked;
    int        evictions;
    int        stat_seen [8];

    function new();
        fiu      = FiuReset;
        use_clk  = 0;
        errors   = 0;
        checked  = 0;
        evictions = 0;
        foreach (page_map[i]) page_map[i] = 8'hFF;
        foreach (proc_id[i]) proc_id[i] = 0;
        foreach (stat_seen[i]) stat_seen[i] = 0;
        clear_frames();
    endfunction

    function void clear_frames();
        for (int i = 0; i < NF; i++)
        begin
            f_used[i]  = 0;
            f_pid[i]   = 0;
            f_page[i]  = 7'h7F;
            f_pin[i]   = 0;
            f_stamp[i] = 0;
        end
    endfunction

    function void set_frames(bit [7:0] v);
        fiu = v;
        clear_frames();
        proc_cnt = 0;
    endfunction

    function int managed();
        return (fiu > NF) ? NF : fiu;
    endfunction

    function int lookup_proc(bit [15:0] pid);
        for (int i = 0; i < proc_cnt && i < NP; i++)
            if (proc_id[i] == pid)
                return i;
        return -1;
    endfunction

    // lowest free frame, else oldest unpinned (lowest index on ties)
    function int grab_frame(ref rsp_t r);
        int v;
        int p;
        bit [31:0] best;
        v = -1;
        best = 0;
        for (int i = 0; i < managed(); i++)
            if (!f_used[i])
                return i;
        for (int i = 0; i < managed(); i++)
            if (f_used[i] && !f_pin[i] && (v < 0 || f_stamp[i] < best))
            begin
                best = f_stamp[i];
                v = i;
            end
        if (v < 0)
            return -1;
        r.evicted      = 1'b1;
        r.evicted_pid  = f_pid[v];
        r.evicted_page = f_page[v][5:0];
        p = lookup_proc(f_pid[v]);
        if (p >= 0 && !f_page[v][6])
            page_map[p*PPP + f_page[v][5:0]] = 8'hFF;
        f_used[v] = 0; f_pid[v] = 0; f_page[v] = 7'h7F; f_pin[v] = 0; f_stamp[v] = 0;
        return v;
    endfunction

    function void note_request(req_t q);
        rsp_t r;
        int f;
        int p;
        bit [7:0] m;
        r = '0;
        if (q.func == FUNC_REGISTER)
        begin
            if (proc_cnt >= NP)
                r.status = STAT_TABLE_FULL;
            else
            begin
                f = grab_frame(r);
                if (f < 0)
                    r.status = STAT_LOAD_NO_FRAME;
                else
                begin
                    use_clk++;
                    f_used[f] = 1; f_pid[f] = q.pid; f_page[f] = 7'h7F;
                    f_pin[f] = 1; f_stamp[f] = use_clk;
                    proc_id[proc_cnt] = q.pid;
                    for (int i = 0; i < PPP; i++)
                        page_map[proc_cnt*PPP + i] = 8'hFF;
                    proc_cnt++;
                    r.status = STAT_LOADED;
                    r.frame  = f[6:0];
                end
            end
        end
        else
        begin
            use_clk++;
            p = lookup_proc(q.pid);
            if (p < 0)
                r.status = STAT_UNKNOWN;
            else
            begin
                m = page_map[p*PPP + q.virtual_page];
                if (!m[7] && f_used[m] && f_pid[m] == q.pid && f_page[m] == {1'b0, q.virtual_page})
                begin
                    f_stamp[m] = use_clk;
                    r.status = STAT_HIT;
                    r.frame  = m[6:0];
                end
                else
                begin
                    f = grab_frame(r);
                    if (f < 0)
                        r.status = STAT_FAULT;
                    else
                    begin
                        f_used[f] = 1; f_pid[f] = q.pid; f_page[f] = {1'b0, q.virtual_page};
                        f_pin[f] = 0; f_stamp[f] = use_clk;
                        page_map[p*PPP + q.virtual_page] = {1'b0, f[6:0]};
                        r.status = STAT_PAGE_IN;
                        r.frame  = f[6:0];
                    end
                end
            end
        end
        pending.push_back(r);
    endfunction

    function void check_response(rsp_t a);
        rsp_t e;
        if (pending.size() == 0)
        begin
            $error("response beat with nothing expected: %p", a);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        stat_seen[e.status]++;
        if (e.evicted) evictions++;
        if (a.status !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
        end
        if (a.frame !== e.frame)
        begin
            $error("frame: expected %0d, got %0d", e.frame, a.frame);
            errors++;
        end
        if (a.evicted !== e.evicted)
        begin
            $error("evicted: expected %0d, got %0d", e.evicted, a.evicted);
            errors++;
        end
        if (a.evicted_pid !== e.evicted_pid)
        begin
            $error("evicted_pid: expected %0d, got %0d", e.evicted_pid, a.evicted_pid);
            errors++;
        end
        if (a.evicted_page !== e.evicted_page)
        begin
            $error("evicted_page: expected %0d, got %0d", e.evicted_page, a.evicted_page);
            errors++;
        end
    endfunction
endclass

module tb_demand_paging_lru_frame_manager_top;

    // watchdog limit: cycles with no beat on either channel
    localparam int STALL_LIMIT = 20000;
    // drain time after last response; one full cell-row walk plus margin
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_data;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    frame_scoreboard sb;

    // idling percentages per phase, set by the stimulus process
    int src_idle_pct;
    int snk_stall_pct;
    int hold_off;          // when nonzero the sink holds off for this many cycles
    int idle_cycles;
    int sent;

    demand_paging_lru_frame_manager_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Monitor: beats sampled on the rising edge. The request is noted
    // before the response so a same-edge pair stays in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("demand_paging_lru_frame_manager_top regression: fail");
            $finish;
        end
    end

    // Response sink: random stalls, plus one long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            rsp_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end
        else
            rsp_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // One request beat; idles randomly first, then holds valid until taken.
    // Valid is left high on return; a later idle or drain() drops it.
    task automatic send_req(input logic f, input logic [15:0] pid, input logic [5:0] vp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{func: f, pid: pid, virtual_page: vp};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Wait for every response, then let the block settle.
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_frames(input logic [7:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_frames(v);
    endtask

    // Random mix: a handful of live pids, mostly registered accesses over a
    // small page set so hits, page-ins and evictions all recur.
    task automatic random_items(input int n, input int pages);
        logic [15:0] pool [4];
        int k;
        for (int i = 0; i < 4; i++)
            pool[i] = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 8)
                send_req(FUNC_REGISTER, pool[$urandom_range(3)], 6'($urandom));
            else if (k < 90)
                send_req(FUNC_ACCESS, pool[$urandom_range(3)],
                         6'($urandom_range(pages - 1)));
            else if (k < 95)
                send_req(FUNC_ACCESS, 16'($urandom), 6'($urandom));
            else
                send_req(FUNC_REGISTER, 16'($urandom), 6'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_off = 0;
        idle_cycles = 0;
        sent = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: default frames, extremes of pid and page, duplicate pid,
        // unknown pid, hit, then a full process table.
        send_req(FUNC_ACCESS, 16'hFFFF, 6'h3F);          // unknown pid
        send_req(FUNC_REGISTER, 16'h0000, 6'h3F);
        send_req(FUNC_REGISTER, 16'hFFFF, 6'h00);
        send_req(FUNC_ACCESS, 16'h0000, 6'h00);          // page in
        send_req(FUNC_ACCESS, 16'h0000, 6'h00);          // hit
        send_req(FUNC_ACCESS, 16'hFFFF, 6'h3F);
        send_req(FUNC_REGISTER, 16'h0000, 6'h15);        // duplicate pid
        send_req(FUNC_ACCESS, 16'h0000, 6'h2A);
        for (int i = 0; i < 8; i++)
            send_req(FUNC_REGISTER, 16'(16'h5A00 + i), 6'h00); // last hits table full

        // Two frames: one page-table frame plus one data frame, so misses
        // evict; a second registration pins the last frame -> no frame.
        write_frames(8'd2);
        send_req(FUNC_REGISTER, 16'h1234, 6'h00);
        send_req(FUNC_ACCESS, 16'h1234, 6'h01);
        send_req(FUNC_ACCESS, 16'h1234, 6'h02);          // evicts page 1
        send_req(FUNC_ACCESS, 16'h1234, 6'h01);
        send_req(FUNC_REGISTER, 16'h4321, 6'h00);        // evicts a data page
        send_req(FUNC_ACCESS, 16'h1234, 6'h03);          // fault: all pinned
        send_req(FUNC_REGISTER, 16'h7777, 6'h00);        // load no frame

        // Zero and one managed frame
        write_frames(8'd0);
        send_req(FUNC_REGISTER, 16'h0001, 6'h00);
        write_frames(8'd1);
        send_req(FUNC_REGISTER, 16'h0001, 6'h00);
        send_req(FUNC_ACCESS, 16'h0001, 6'h05);

        // Random phases across settings and idling patterns
        write_frames(8'd6);
        random_items(80, 12);
        write_frames(8'd255);                           // clamps to all frames
        src_idle_pct = 63;
        random_items(70, 64);
        write_frames(8'd12);
        src_idle_pct = 0;
        snk_stall_pct = 63;
        random_items(80, 20);

        // Long receiver hold-off while requests keep coming
        snk_stall_pct = 0;
        hold_off = 600;
        random_items(20, 20);

        // Sender pauses until everything has come back
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        write_frames(8'd4);
        src_idle_pct = 7;
        snk_stall_pct = 7;
        random_items(80, 8);
        write_frames(8'd128);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        random_items(40, 64);

        drain();
        $display("covered %0d requests, %0d responses checked, %0d evictions",
                 sent, sb.checked, sb.evictions);
        $display("status counts hit/in/fault/unknown/loaded/full/noframe: %0d %0d %0d %0d %0d %0d %0d",
                 sb.stat_seen[0], sb.stat_seen[1], sb.stat_seen[2], sb.stat_seen[3],
                 sb.stat_seen[4], sb.stat_seen[5], sb.stat_seen[6]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("demand_paging_lru_frame_manager_top regression: pass");
        else
            $display("demand_paging_lru_frame_manager_top regression: fail");
        $finish;
    end

endmodule
